@@ rtl/core/four_register_instruction_executor_macros.svh @@
// Assertion macros used by the instruction executor top level.
`ifndef FOUR_REGISTER_INSTRUCTION_EXECUTOR_MACROS_SVH
`define FOUR_REGISTER_INSTRUCTION_EXECUTOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define FRIE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define FRIE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/frie_pkg.sv @@
// Types, codes and constants shared by the instruction executor modules.
package frie_pkg;

  // Datapath sizes.
  localparam int REG_WIDTH   = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int NUM_REGS    = 4;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);
  localparam int DIV_CNT_W   = $clog2(REG_WIDTH);

  // Command queue between the front and back ends.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Input action codes.
  localparam logic [3:0] ACT_MOV     = 4'd0;
  localparam logic [3:0] ACT_ADD     = 4'd1;
  localparam logic [3:0] ACT_SUB     = 4'd2;
  localparam logic [3:0] ACT_MUL     = 4'd3;
  localparam logic [3:0] ACT_DIV     = 4'd4;
  localparam logic [3:0] ACT_INC     = 4'd5;
  localparam logic [3:0] ACT_DEC     = 4'd6;
  localparam logic [3:0] ACT_END     = 4'd7;
  localparam logic [3:0] ACT_RESTART = 4'd9;

  // Highest legal destination register code.
  localparam logic [2:0] DEST_MAX = 3'd3;

  // Source operand kinds.
  localparam logic [1:0] KIND_REG = 2'd0;
  localparam logic [1:0] KIND_IMM = 2'd1;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_DIVZERO = 3'd1,
    STAT_BADOPND = 3'd2,
    STAT_BADREG  = 3'd3,
    STAT_BADOP   = 3'd4,
    STAT_END     = 3'd5,
    STAT_HALTED  = 3'd6
  } status_e;

  // Classified operation handed from the front end to the back end.
  typedef enum logic [3:0] {
    OP_MOV,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_INC,
    OP_DEC,
    OP_END,
    OP_BADOP,
    OP_BADREG,
    OP_BADOPND,
    OP_RESTART
  } op_e;

  // One input beat.
  typedef struct packed {
    logic [3:0]  action;
    logic [2:0]  dest_reg;
    logic [1:0]  src_kind;
    logic [1:0]  src_reg;
    logic [30:0] immediate;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic signed [REG_WIDTH-1:0] reg_a;
    logic signed [REG_WIDTH-1:0] reg_b;
    logic signed [REG_WIDTH-1:0] reg_c;
    logic signed [REG_WIDTH-1:0] reg_d;
    logic [COUNT_WIDTH-1:0]      program_count;
    status_e                     status;
  } result_t;

  // Decoded command.
  typedef struct packed {
    op_e                  op;
    logic [REG_IDX_W-1:0] dest;
    logic                 src_imm;
    logic [REG_IDX_W-1:0] src_reg;
    logic [REG_WIDTH-1:0] imm_val;
  } cmd_t;

  // Divider request and response.
  typedef struct packed {
    logic                 start;
    logic [REG_WIDTH-1:0] dividend;
    logic [REG_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [REG_WIDTH-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/core/frie_front.sv @@
// Front end: accepts input beats and classifies them into commands.
module frie_front import frie_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  cmd_valid_o,
  output cmd_t  cmd_o,
  input  logic  cmd_ready_i
);

  logic  valid_q, valid_d;
  cmd_t  cmd_q;
  cmd_t  cmd_class;
  logic  accept;

  // The holding register frees up whenever the queue takes its command.
  assign full_o      = valid_q && !cmd_ready_i;
  assign accept      = push_i && !full_o;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  // Classification follows the priority of the instruction checks.
  always_comb begin
    cmd_class.dest    = item_i.dest_reg[REG_IDX_W-1:0];
    cmd_class.src_imm = (item_i.src_kind == KIND_IMM);
    cmd_class.src_reg = item_i.src_reg;
    cmd_class.imm_val = REG_WIDTH'(item_i.immediate);
    if (item_i.action == ACT_RESTART) begin
      cmd_class.op = OP_RESTART;
    end else if (item_i.action == ACT_END) begin
      cmd_class.op = OP_END;
    end else if (item_i.action > ACT_DEC) begin
      cmd_class.op = OP_BADOP;
    end else if (item_i.dest_reg > DEST_MAX) begin
      cmd_class.op = OP_BADREG;
    end else if (item_i.action == ACT_INC) begin
      cmd_class.op = OP_INC;
    end else if (item_i.action == ACT_DEC) begin
      cmd_class.op = OP_DEC;
    end else if (item_i.src_kind != KIND_REG && item_i.src_kind != KIND_IMM) begin
      cmd_class.op = OP_BADOPND;
    end else begin
      unique case (item_i.action)
        ACT_MOV: cmd_class.op = OP_MOV;
        ACT_ADD: cmd_class.op = OP_ADD;
        ACT_SUB: cmd_class.op = OP_SUB;
        ACT_MUL: cmd_class.op = OP_MUL;
        ACT_DIV: cmd_class.op = OP_DIV;
        default: cmd_class.op = OP_BADOP;
      endcase
    end
  end

  // Valid flag of the holding register.
  always_comb begin
    valid_d = valid_q;
    if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Command payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_class;
    end
  end

endmodule

@@ rtl/core/frie_queue.sv @@
// Short command queue that decouples the front end from the back end.
module frie_queue import frie_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  input  cmd_t wr_data_i,
  output logic wr_ready_o,
  output logic rd_valid_o,
  output cmd_t rd_data_o,
  input  logic rd_pop_i
);

  cmd_t                   entries_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   do_wr;
  logic                   do_rd;

  assign wr_ready_o = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = entries_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_pop_i && rd_valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entries_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ rtl/core/frie_div.sv @@
// Radix-2 restoring signed divider, one quotient bit per cycle.
module frie_div import frie_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_DONE
  } dv_state_e;

  dv_state_e              state_q, state_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [REG_WIDTH-1:0]   rem_q, rem_d;
  logic [REG_WIDTH-1:0]   quo_q, quo_d;
  logic [REG_WIDTH-1:0]   dvs_q, dvs_d;
  logic                   neg_q, neg_d;
  logic [REG_WIDTH:0]     trial;
  logic [REG_WIDTH:0]     diff;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {rem_q, quo_q[REG_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    unique case (state_q)
      DV_IDLE: begin
        if (req_i.start) begin
          quo_d   = req_i.dividend[REG_WIDTH-1] ? (~req_i.dividend) + 1'b1 : req_i.dividend;
          dvs_d   = req_i.divisor[REG_WIDTH-1] ? (~req_i.divisor) + 1'b1 : req_i.divisor;
          rem_d   = '0;
          neg_d   = req_i.dividend[REG_WIDTH-1] ^ req_i.divisor[REG_WIDTH-1];
          cnt_d   = DIV_CNT_W'(REG_WIDTH - 1);
          state_d = DV_RUN;
        end
      end
      DV_RUN: begin
        if (!diff[REG_WIDTH]) begin
          rem_d = diff[REG_WIDTH-1:0];
          quo_d = {quo_q[REG_WIDTH-2:0], 1'b1};
        end else begin
          rem_d = trial[REG_WIDTH-1:0];
          quo_d = {quo_q[REG_WIDTH-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          state_d = DV_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      DV_DONE: begin
        state_d = DV_IDLE;
      end
      default: begin
        state_d = DV_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  // The sign is applied to the magnitude quotient on the way out.
  assign rsp_o.busy     = (state_q != DV_IDLE);
  assign rsp_o.done     = (state_q == DV_DONE);
  assign rsp_o.quotient = neg_q ? (~quo_q) + 1'b1 : quo_q;

endmodule

@@ rtl/core/frie_back.sv @@
// Back end: register file, execution sequencer and result register.
module frie_back import frie_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  cmd_t     cmd_i,
  output logic     cmd_pop_o,
  output div_req_t div_req_o,
  input  div_rsp_t div_rsp_i,
  output logic     res_empty_o,
  input  logic     res_pop_i,
  output result_t  res_o
);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_DIV
  } bk_state_e;

  bk_state_e              state_q, state_d;
  cmd_t                   cmd_q, cmd_d;
  logic [REG_WIDTH-1:0]   opd_q, opd_d;
  logic [REG_WIDTH-1:0]   ops_q, ops_d;
  logic [REG_WIDTH-1:0]   regs_q [NUM_REGS];
  logic [REG_WIDTH-1:0]   regs_d [NUM_REGS];
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   halted_q, halted_d;
  logic                   out_valid_q, out_valid_d;
  result_t                out_q, out_d;
  logic [REG_WIDTH-1:0]   alu_res;
  logic                   load_out;
  status_e                status;

  // Combinational arithmetic on the registered operands.
  always_comb begin
    unique case (cmd_q.op)
      OP_MOV:  alu_res = ops_q;
      OP_ADD:  alu_res = opd_q + ops_q;
      OP_SUB:  alu_res = opd_q - ops_q;
      OP_MUL:  alu_res = opd_q * ops_q;
      OP_INC:  alu_res = opd_q + 1'b1;
      OP_DEC:  alu_res = opd_q - 1'b1;
      default: alu_res = opd_q;
    endcase
  end

  // Sequencer: read operands, execute, then wait for the divider if needed.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    opd_d       = opd_q;
    ops_d       = ops_q;
    regs_d      = regs_q;
    count_d     = count_q;
    halted_d    = halted_q;
    out_valid_d = out_valid_q && !res_pop_i;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    load_out    = 1'b0;
    status      = STAT_OK;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = opd_q;
    div_req_o.divisor  = ops_q;

    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && (!out_valid_q || res_pop_i)) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          opd_d     = regs_q[cmd_i.dest];
          ops_d     = cmd_i.src_imm ? cmd_i.imm_val : regs_q[cmd_i.src_reg];
          state_d   = BK_EXEC;
        end
      end
      BK_EXEC: begin
        state_d  = BK_IDLE;
        load_out = 1'b1;
        if (cmd_q.op == OP_RESTART) begin
          for (int i = 0; i < NUM_REGS; i++) begin
            regs_d[i] = '0;
          end
          count_d  = '0;
          halted_d = 1'b0;
        end else if (halted_q) begin
          status = STAT_HALTED;
        end else begin
          case (cmd_q.op)
            OP_END: begin
              count_d  = '0;
              halted_d = 1'b1;
              status   = STAT_END;
            end
            OP_BADOP: begin
              count_d  = '0;
              halted_d = 1'b1;
              status   = STAT_BADOP;
            end
            OP_BADREG: begin
              count_d  = '0;
              halted_d = 1'b1;
              status   = STAT_BADREG;
            end
            OP_BADOPND: begin
              count_d  = '0;
              halted_d = 1'b1;
              status   = STAT_BADOPND;
            end
            OP_DIV: begin
              count_d = count_q + 1'b1;
              if (ops_q == '0) begin
                status = STAT_DIVZERO;
              end else begin
                div_req_o.start = 1'b1;
                load_out        = 1'b0;
                state_d         = BK_DIV;
              end
            end
            default: begin
              regs_d[cmd_q.dest] = alu_res;
              count_d            = count_q + 1'b1;
            end
          endcase
        end
      end
      BK_DIV: begin
        if (div_rsp_i.done) begin
          regs_d[cmd_q.dest] = div_rsp_i.quotient;
          load_out           = 1'b1;
          state_d            = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    // The result shows the architectural state after this instruction.
    if (load_out) begin
      out_valid_d         = 1'b1;
      out_d.reg_a         = regs_d[0];
      out_d.reg_b         = regs_d[1];
      out_d.reg_c         = regs_d[2];
      out_d.reg_d         = regs_d[3];
      out_d.program_count = count_d;
      out_d.status        = status;
    end
  end

  // Control state and architectural registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      halted_q    <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      halted_q    <= halted_d;
      regs_q      <= regs_d;
    end
  end

  // Command, operand and result payload.
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    opd_q <= opd_d;
    ops_q <= ops_d;
    out_q <= out_d;
  end

  assign res_empty_o = !out_valid_q;
  assign res_o       = out_q;

endmodule

@@ rtl/core/four_register_instruction_executor.sv @@
// Path of a beat: front holding register, command queue, operand read, execute, result register.
// The back end takes no new instruction until the last has passed its operand read and execute steps.
// A divide by a nonzero value also waits for the divider, which makes one quotient bit per cycle.
// A two-entry command queue lets the front end keep accepting while the back end works.
// Asynchronous reset clears the registers, the count, the halt flag and the command queue.
// No clearing pass follows reset; the block accepts beats in the first cycle after it.
`include "four_register_instruction_executor_macros.svh"

module four_register_instruction_executor import frie_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  input  item_t   item_i,
  output logic    full,
  output logic    empty,
  input  logic    pop,
  output result_t result_o
);

  logic     front_valid;
  cmd_t     front_cmd;
  logic     q_ready;
  logic     q_valid;
  cmd_t     q_head;
  logic     q_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Front end: accept and classify.
  frie_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (item_i),
    .full_o      (full),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd),
    .cmd_ready_i (q_ready)
  );

  // Command queue between the two halves.
  frie_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_data_i  (front_cmd),
    .wr_ready_o (q_ready),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_head),
    .rd_pop_i   (q_pop)
  );

  // Back end: execute and hold the result.
  frie_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_head),
    .cmd_pop_o   (q_pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .res_empty_o (empty),
    .res_pop_i   (pop),
    .res_o       (result_o)
  );

  // Iterative divider used by the back end.
  frie_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // A new division starts only on an idle divider.
  `FRIE_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
  // The result slot stays free while a division is running.
  `FRIE_ASSERT_IMP(a_div_out_free, div_rsp.busy, empty, "result pending during a division")
  // A finished division shows up as a result in the next cycle.
  `FRIE_ASSERT_NXT(a_div_done_out, div_rsp.done, !empty, "division finished without a result")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the four-register instruction executor.
`timescale 1ns / 100ps

module tb_top;
  import frie_pkg::*;

  // Codes the package does not name.
  localparam logic [3:0] ACT_UNKNOWN   = 4'd8;
  localparam logic [3:0] ACT_UNUSED_LO = 4'd10;
  localparam logic [3:0] ACT_UNUSED_HI = 4'd15;
  localparam logic [2:0] DST_AX        = 3'd0;
  localparam logic [2:0] DST_BX        = 3'd1;
  localparam logic [2:0] DST_CX        = 3'd2;
  localparam logic [2:0] DST_DX        = 3'd3;
  localparam logic [2:0] DST_BAD_LO    = 3'd4;
  localparam logic [2:0] DST_BAD_HI    = 3'd7;
  localparam logic [1:0] SRC_AX        = 2'd0;
  localparam logic [1:0] SRC_BX        = 2'd1;
  localparam logic [1:0] SRC_CX        = 2'd2;
  localparam logic [1:0] SRC_DX        = 2'd3;
  localparam logic [1:0] KIND_BAD_LO   = 2'd2;
  localparam logic [1:0] KIND_BAD_HI   = 2'd3;

  localparam int RANDOM_ITEMS   = 1650;
  localparam int MAX_GAP        = 5;
  localparam int DRAIN_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } dir_row_t;

  logic    clk_i;
  logic    rst_ni;
  logic    push;
  logic    pop;
  logic    full;
  logic    empty;
  item_t   item_i;
  result_t result_o;

  // Architectural state as the predictor sees it.
  logic [REG_WIDTH-1:0]   arch_regs [NUM_REGS];
  logic [COUNT_WIDTH-1:0] arch_count;
  bit                     arch_halted;

  result_t  expected_results [$];
  dir_row_t dir_rows [$];
  int       errors;
  int       idle_cycles;
  bit       tx_steady;
  bit       rx_steady;

  four_register_instruction_executor i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .item_i   (item_i),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic item_t mk_item(logic [3:0] act, logic [2:0] dst, logic [1:0] kind,
                                    logic [1:0] sreg, logic [30:0] imm);
    item_t it;
    it.action    = act;
    it.dest_reg  = dst;
    it.src_kind  = kind;
    it.src_reg   = sreg;
    it.immediate = imm;
    return it;
  endfunction

  function automatic result_t mk_res(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                     logic [31:0] d, logic [15:0] pc, status_e st);
    result_t res;
    res.reg_a         = a;
    res.reg_b         = b;
    res.reg_c         = c;
    res.reg_d         = d;
    res.program_count = pc;
    res.status        = st;
    return res;
  endfunction

  function automatic void add_row(item_t it, bit typed, result_t res);
    dir_row_t row;
    row.it    = it;
    row.typed = typed;
    row.res   = res;
    dir_rows.push_back(row);
  endfunction

  // Executes one instruction on the predicted state and returns the result beat.
  function automatic result_t execute_instr(item_t it);
    logic [REG_WIDTH-1:0] d;
    logic [REG_WIDTH-1:0] s;
    logic [REG_WIDTH-1:0] r;
    logic [REG_WIDTH-1:0] mag_d;
    logic [REG_WIDTH-1:0] mag_s;
    logic [REG_WIDTH-1:0] quo;
    status_e              st;
    result_t              res;
    st = STAT_OK;
    r  = '0;
    if (it.action == ACT_RESTART) begin
      for (int i = 0; i < NUM_REGS; i++) arch_regs[i] = '0;
      arch_count  = '0;
      arch_halted = 1'b0;
    end else if (arch_halted) begin
      st = STAT_HALTED;
    end else if (it.action == ACT_END) begin
      st = STAT_END;
    end else if (it.action > ACT_DEC) begin
      st = STAT_BADOP;
    end else if (it.dest_reg > DEST_MAX) begin
      // The destination is checked before the source operand.
      st = STAT_BADREG;
    end else begin
      d = arch_regs[it.dest_reg[1:0]];
      if (it.action == ACT_INC || it.action == ACT_DEC) begin
        // Stepping ignores every source field.
        arch_regs[it.dest_reg[1:0]] = (it.action == ACT_INC) ? d + 1'b1 : d - 1'b1;
        arch_count = arch_count + 1'b1;
      end else if (it.src_kind != KIND_REG && it.src_kind != KIND_IMM) begin
        st = STAT_BADOPND;
      end else begin
        s = (it.src_kind == KIND_REG) ? arch_regs[it.src_reg] : {1'b0, it.immediate};
        arch_count = arch_count + 1'b1;
        case (it.action)
          ACT_MOV: r = s;
          ACT_ADD: r = d + s;
          ACT_SUB: r = d - s;
          ACT_MUL: r = d * s;
          default: begin
            // Signed division by magnitudes, truncating toward zero.
            if (s == '0) begin
              st = STAT_DIVZERO;
            end else begin
              mag_d = d[REG_WIDTH-1] ? -d : d;
              mag_s = s[REG_WIDTH-1] ? -s : s;
              quo   = mag_d / mag_s;
              r     = (d[REG_WIDTH-1] != s[REG_WIDTH-1]) ? -quo : quo;
            end
          end
        endcase
        if (st == STAT_OK) arch_regs[it.dest_reg[1:0]] = r;
      end
    end
    // END and any error but a divide by zero halt the block and clear the count.
    if (st inside {STAT_END, STAT_BADOP, STAT_BADREG, STAT_BADOPND}) begin
      arch_count  = '0;
      arch_halted = 1'b1;
    end
    res = mk_res(arch_regs[0], arch_regs[1], arch_regs[2], arch_regs[3], arch_count, st);
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Presents one beat after a random gap (none while tx_steady is set) and returns at the edge that accepts it.
  task automatic drive_item(input item_t it);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push   <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    if ($urandom_range(0, 39) == 0) tx_steady = ~tx_steady;
  endtask

  // Result side: random pop gaps, each accepted beat checked against the oldest expectation.
  initial begin : result_side
    int      gap;
    result_t exp_res;
    wait (rst_ni);
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      repeat (gap) begin
        pop <= 1'b0;
        @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with no expectation waiting: expected none actual %h",
                 $time, result_o);
        errors++;
      end else begin
        exp_res = expected_results.pop_front();
        check_field("reg_a", exp_res.reg_a, result_o.reg_a);
        check_field("reg_b", exp_res.reg_b, result_o.reg_b);
        check_field("reg_c", exp_res.reg_c, result_o.reg_c);
        check_field("reg_d", exp_res.reg_d, result_o.reg_d);
        check_field("program_count", 32'(exp_res.program_count),
                    32'(result_o.program_count));
        check_field("status", 32'(exp_res.status), 32'(result_o.status));
      end
      if ($urandom_range(0, 39) == 0) rx_steady = ~rx_steady;
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Stimulus, prediction and the end of the run.
  initial begin : stimulus
    item_t   it;
    result_t predicted;
    int      pick;
    int      n_done;
    bit      ignored;

    rst_ni      = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    item_i      = '0;
    errors      = 0;
    idle_cycles = 0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    for (int i = 0; i < NUM_REGS; i++) arch_regs[i] = '0;
    arch_count  = '0;
    arch_halted = 1'b0;

    // Directed rows: wraps, division corners, every operation and every error code.
    add_row(mk_item(ACT_MOV, DST_AX, KIND_IMM, SRC_AX, 31'h7FFF_FFFF), 1'b1,
            mk_res(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 16'd1, STAT_OK));
    add_row(mk_item(ACT_INC, DST_AX, KIND_REG, SRC_AX, 31'h0), 1'b1,
            mk_res(32'h8000_0000, 32'h0, 32'h0, 32'h0, 16'd2, STAT_OK));
    add_row(mk_item(ACT_DIV, DST_AX, KIND_IMM, SRC_AX, 31'h0), 1'b1,
            mk_res(32'h8000_0000, 32'h0, 32'h0, 32'h0, 16'd3, STAT_DIVZERO));
    add_row(mk_item(ACT_DEC, DST_BX, KIND_REG, SRC_AX, 31'h0), 1'b1,
            mk_res(32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 16'd4, STAT_OK));
    add_row(mk_item(ACT_DIV, DST_AX, KIND_REG, SRC_BX, 31'h0), 1'b1,
            mk_res(32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 16'd5, STAT_OK));
    add_row(mk_item(ACT_DIV, DST_BX, KIND_REG, SRC_CX, 31'h0), 1'b1,
            mk_res(32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 16'd6, STAT_DIVZERO));
    add_row(mk_item(ACT_MOV, DST_CX, KIND_REG, SRC_BX, 31'h0), 1'b0, '0);
    add_row(mk_item(ACT_ADD, DST_DX, KIND_IMM, SRC_AX, 31'h7FFF_FFFF), 1'b0, '0);
    add_row(mk_item(ACT_ADD, DST_DX, KIND_REG, SRC_DX, 31'h0), 1'b0, '0);
    add_row(mk_item(ACT_SUB, DST_DX, KIND_REG, SRC_AX, 31'h0), 1'b0, '0);
    add_row(mk_item(ACT_MUL, DST_CX, KIND_IMM, SRC_AX, 31'd12345), 1'b0, '0);
    add_row(mk_item(ACT_DIV, DST_CX, KIND_IMM, SRC_AX, 31'd7), 1'b0, '0);
    add_row(mk_item(ACT_INC, DST_DX, KIND_BAD_HI, SRC_DX, 31'h7FFF_FFFF), 1'b0, '0);
    add_row(mk_item(ACT_DEC, DST_AX, KIND_BAD_LO, SRC_CX, 31'h0), 1'b0, '0);
    add_row(mk_item(ACT_RESTART, DST_AX, KIND_REG, SRC_AX, 31'h0), 1'b1,
            mk_res(32'h0, 32'h0, 32'h0, 32'h0, 16'd0, STAT_OK));
    add_row(mk_item(ACT_MOV, DST_BAD_HI, KIND_BAD_LO, SRC_AX, 31'h0), 1'b1,
            mk_res(32'h0, 32'h0, 32'h0, 32'h0, 16'd0, STAT_BADREG));
    add_row(mk_item(ACT_RESTART, DST_AX, KIND_REG, SRC_AX, 31'h0), 1'b1,
            mk_res(32'h0, 32'h0, 32'h0, 32'h0, 16'd0, STAT_OK));
    add_row(mk_item(ACT_SUB, DST_AX, KIND_BAD_HI, SRC_AX, 31'h0), 1'b1,
            mk_res(32'h0, 32'h0, 32'h0, 32'h0, 16'd0, STAT_BADOPND));
    add_row(mk_item(ACT_RESTART, DST_AX, KIND_REG, SRC_AX, 31'h0), 1'b1,
            mk_res(32'h0, 32'h0, 32'h0, 32'h0, 16'd0, STAT_OK));
    add_row(mk_item(ACT_UNKNOWN, DST_AX, KIND_REG, SRC_AX, 31'h0), 1'b1,
            mk_res(32'h0, 32'h0, 32'h0, 32'h0, 16'd0, STAT_BADOP));
    add_row(mk_item(ACT_RESTART, DST_AX, KIND_REG, SRC_AX, 31'h0), 1'b1,
            mk_res(32'h0, 32'h0, 32'h0, 32'h0, 16'd0, STAT_OK));
    add_row(mk_item(ACT_INC, DST_AX, KIND_REG, SRC_AX, 31'h0), 1'b1,
            mk_res(32'h1, 32'h0, 32'h0, 32'h0, 16'd1, STAT_OK));
    add_row(mk_item(ACT_END, DST_AX, KIND_REG, SRC_AX, 31'h0), 1'b1,
            mk_res(32'h1, 32'h0, 32'h0, 32'h0, 16'd0, STAT_END));
    add_row(mk_item(ACT_END, DST_AX, KIND_REG, SRC_AX, 31'h0), 1'b1,
            mk_res(32'h1, 32'h0, 32'h0, 32'h0, 16'd0, STAT_HALTED));
    add_row(mk_item(ACT_RESTART, DST_AX, KIND_REG, SRC_AX, 31'h0), 1'b1,
            mk_res(32'h0, 32'h0, 32'h0, 32'h0, 16'd0, STAT_OK));

    // Hold reset, then release it at a rising edge.
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: typed-in rows keep their own expectation, the others use the predictor.
    foreach (dir_rows[i]) begin
      drive_item(dir_rows[i].it);
      predicted = execute_instr(dir_rows[i].it);
      expected_results.push_back(dir_rows[i].typed ? dir_rows[i].res : predicted);
    end

    // Random part: mostly well-formed instructions, with errors, halts and noise mixed in.
    n_done = 0;
    while (n_done < RANDOM_ITEMS) begin
      it.action    = 4'($urandom_range(ACT_MOV, ACT_DEC));
      it.dest_reg  = 3'($urandom_range(DST_AX, DST_DX));
      it.src_kind  = 2'($urandom_range(KIND_REG, KIND_IMM));
      it.src_reg   = 2'($urandom_range(SRC_AX, SRC_DX));
      case ($urandom_range(0, 3))
        0:       it.immediate = 31'($urandom_range(0, 16));
        1:       it.immediate = 31'($urandom);
        2:       it.immediate = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0;
        default: it.immediate = 31'($urandom_range(1, 1000));
      endcase
      pick = $urandom_range(0, 99);
      if (arch_halted) begin
        if (pick < 75) begin
          it.action = ACT_RESTART;
        end else begin
          it.action   = 4'($urandom);
          it.dest_reg = 3'($urandom);
          it.src_kind = 2'($urandom);
        end
      end else if (pick >= 97) begin
        it.action   = 4'($urandom_range(ACT_MOV, ACT_DIV));
        it.src_kind = 2'($urandom_range(KIND_BAD_LO, KIND_BAD_HI));
      end else if (pick >= 95) begin
        it.dest_reg = 3'($urandom_range(DST_BAD_LO, DST_BAD_HI));
      end else if (pick >= 93) begin
        it.action = $urandom_range(0, 1) ? ACT_UNKNOWN
                                         : 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      end else if (pick >= 91) begin
        it.action = ACT_RESTART;
      end else if (pick >= 88) begin
        it.action = ACT_END;
      end
      ignored = arch_halted && (it.action != ACT_RESTART);
      drive_item(it);
      expected_results.push_back(execute_instr(it));
      if (!ignored) begin
        n_done++;
        // Now and then hold the sender until every expected result is back.
        if (n_done % 550 == 275) begin
          push <= 1'b0;
          while (expected_results.size() != 0) @(posedge clk_i);
        end
      end
    end
    push <= 1'b0;

    // Drain, then allow the block's latency before the verdict.
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
